// ===== src/stun_xor_mapped_address_parser_core_assert.svh =====
// assertion macros used by the stun xor-mapped-address parser core
`ifndef STUN_XOR_MAPPED_ADDRESS_PARSER_CORE_ASSERT_SVH
`define STUN_XOR_MAPPED_ADDRESS_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SXMA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sxma assertion failed");

// next-cycle implication
`define SXMA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sxma assertion failed");

`else

`define SXMA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SXMA_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== src/sxma_pkg.sv =====
// types and constants of the stun xor-mapped-address parser
package sxma_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } sxma_in_t;

  typedef struct packed {
    logic        found;
    logic        too_short;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
  } sxma_out_t;

  localparam int unsigned OFS_W = 17;

  localparam logic [OFS_W-1:0] HDR_BYTES = 17'd20;
  localparam logic [15:0]      XMA_TYPE  = 16'h0020;
  localparam logic [7:0]       FAMILY_V4 = 8'h01;
  localparam logic [31:0]      COOKIE    = 32'h2112A442;
  localparam logic [15:0]      MIN_XMA_LEN = 16'd8;

  // byte offsets inside one attribute
  localparam logic [OFS_W-1:0] REL_KIND_HI = 17'd0;
  localparam logic [OFS_W-1:0] REL_KIND_LO = 17'd1;
  localparam logic [OFS_W-1:0] REL_LEN_HI  = 17'd2;
  localparam logic [OFS_W-1:0] REL_LEN_LO  = 17'd3;
  localparam logic [OFS_W-1:0] REL_FAMILY  = 17'd5;
  localparam logic [OFS_W-1:0] REL_PORT_HI = 17'd6;
  localparam logic [OFS_W-1:0] REL_PORT_LO = 17'd7;
  localparam logic [OFS_W-1:0] REL_IP_0    = 17'd8;
  localparam logic [OFS_W-1:0] REL_IP_1    = 17'd9;
  localparam logic [OFS_W-1:0] REL_IP_2    = 17'd10;
  localparam logic [OFS_W-1:0] REL_IP_3    = 17'd11;
  localparam logic [OFS_W-1:0] ATTR_HDR    = 17'd4;

endpackage

// ===== src/sxma_walker.sv =====
// attribute walk state and per-byte update of the parser
module sxma_walker #(
  parameter int unsigned MAX_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sxma_pkg::sxma_in_t  item,
  output sxma_pkg::sxma_out_t result
);
  import sxma_pkg::*;

  localparam int unsigned PW = $clog2(MAX_BYTES + 1);

  logic [PW-1:0]    byte_position, byte_position_next;
  logic [OFS_W-1:0] attr_offset, attr_offset_next;
  logic [15:0]      attr_kind, attr_kind_next;
  logic [15:0]      attr_length, attr_length_next;
  logic [OFS_W-1:0] attr_span, attr_span_next;
  logic             match_done, match_done_next;
  logic             match_candidate, match_candidate_next;
  logic [31:0]      held_ip, held_ip_next;
  logic [15:0]      held_port, held_port_next;

  logic [OFS_W-1:0] pos_ext;
  logic [OFS_W-1:0] body_pos;
  logic [OFS_W-1:0] rel;
  logic             in_attr;
  logic             matched_now;
  logic [15:0]      len_new;
  logic [1:0]       pad;
  logic             short_msg;

  assign pos_ext  = OFS_W'(byte_position);
  assign body_pos = pos_ext - HDR_BYTES;
  assign rel      = body_pos - attr_offset;
  assign in_attr  = (pos_ext >= HDR_BYTES) && (body_pos >= attr_offset);
  assign len_new  = {attr_length[15:8], item.data_byte};
  assign pad      = 2'(2'd0 - len_new[1:0]);

  always_comb begin
    byte_position_next   = byte_position;
    attr_offset_next     = attr_offset;
    attr_kind_next       = attr_kind;
    attr_length_next     = attr_length;
    attr_span_next       = attr_span;
    match_done_next      = match_done;
    match_candidate_next = match_candidate;
    held_ip_next         = held_ip;
    held_port_next       = held_port;
    matched_now          = 1'b0;

    if (take && (byte_position < PW'(MAX_BYTES))) begin
      byte_position_next = byte_position + PW'(1);
      if (!match_done && in_attr) begin
        case (rel)
          REL_KIND_HI: attr_kind_next = {item.data_byte, 8'h00};
          REL_KIND_LO: attr_kind_next = {attr_kind[15:8], item.data_byte};
          REL_LEN_HI:  attr_length_next = {item.data_byte, 8'h00};
          REL_LEN_LO: begin
            attr_length_next = len_new;
            attr_span_next   = ATTR_HDR + OFS_W'(len_new) + OFS_W'(pad);
          end
          REL_FAMILY: match_candidate_next = (attr_kind == XMA_TYPE) &&
                                             (attr_length >= MIN_XMA_LEN) &&
                                             (item.data_byte == FAMILY_V4);
          REL_PORT_HI: held_port_next = {item.data_byte, 8'h00};
          REL_PORT_LO: held_port_next = {held_port[15:8], item.data_byte};
          REL_IP_0, REL_IP_1, REL_IP_2: held_ip_next = {held_ip[23:0], item.data_byte};
          REL_IP_3: begin
            held_ip_next = {held_ip[23:0], item.data_byte};
            if (match_candidate) begin
              matched_now     = 1'b1;
              match_done_next = 1'b1;
              held_ip_next    = {held_ip[23:0], item.data_byte} ^ COOKIE;
              held_port_next  = held_port ^ COOKIE[31:16];
            end
          end
          default: ;
        endcase

        // end of this attribute: move to the next one
        if (!matched_now && (rel >= REL_LEN_LO) &&
            ((18'(rel) + 18'd1) == 18'(attr_span_next))) begin
          attr_offset_next     = attr_offset + attr_span_next;
          match_candidate_next = 1'b0;
          held_ip_next         = '0;
          held_port_next       = '0;
        end
      end
    end

    short_msg = (OFS_W'(byte_position_next) < HDR_BYTES);
    result.found       = match_done_next;
    result.too_short   = short_msg;
    result.mapped_ip   = match_done_next ? held_ip_next : '0;
    result.mapped_port = match_done_next ? held_port_next : '0;

    // message ends: start fresh for the next one
    if (take && item.last) begin
      byte_position_next   = '0;
      attr_offset_next     = '0;
      attr_kind_next       = '0;
      attr_length_next     = '0;
      attr_span_next       = '0;
      match_done_next      = 1'b0;
      match_candidate_next = 1'b0;
      held_ip_next         = '0;
      held_port_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      attr_offset     <= '0;
      attr_kind       <= '0;
      attr_length     <= '0;
      attr_span       <= '0;
      match_done      <= 1'b0;
      match_candidate <= 1'b0;
      held_ip         <= '0;
      held_port       <= '0;
    end else begin
      byte_position   <= byte_position_next;
      attr_offset     <= attr_offset_next;
      attr_kind       <= attr_kind_next;
      attr_length     <= attr_length_next;
      attr_span       <= attr_span_next;
      match_done      <= match_done_next;
      match_candidate <= match_candidate_next;
      held_ip         <= held_ip_next;
      held_port       <= held_port_next;
    end
  end

endmodule

// ===== src/stun_xor_mapped_address_parser_core.sv =====
// stun xor-mapped-address parser: usage
// in channel: one message byte per transfer (in_data.data_byte), with
//   in_data.last set on the final byte of the message.
// out channel: one transfer per message, issued for the byte marked last:
//   found, too_short, mapped_ip and mapped_port (zero when not found).
// the last byte, once accepted, sits in the input register; the result
//   register loads when that byte leaves the input register.
// throughput: one byte per cycle when not stalled; each byte makes a single
//   update of the attribute walk state between the input register and walker.
// bytes beyond MAX_BYTES of one message are dropped, but a last marker on
//   such a byte still produces the result.
// receiver stall: the result register holds its value; non-last bytes keep
//   flowing, and a last byte waits in the input register (stalling the
//   sender) only while the previous result has not been taken.
// reset: synchronous and active high; clears the walk state and empties the
//   input register and the result register, with no clearing pass afterwards.
module stun_xor_mapped_address_parser_core #(
  parameter int unsigned MAX_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sxma_pkg::sxma_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sxma_pkg::sxma_out_t out_data
);
  import sxma_pkg::*;

  `include "stun_xor_mapped_address_parser_core_assert.svh"

  logic      stage_valid;
  sxma_in_t  stage;
  logic      out_free;
  logic      advance;
  logic      in_take;
  sxma_out_t walk_result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = stage_valid && (!stage.last || out_free);
  assign in_stall = stage_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage <= in_data;
    end
  end

  sxma_walker #(
    .MAX_BYTES(MAX_BYTES)
  ) u_walker (
    .clk   (clk),
    .rst   (rst),
    .take  (advance),
    .item  (stage),
    .result(walk_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last) begin
      out_data <= walk_result;
    end
  end

  `SXMA_ASSERT_IMP(a_body_no_stall, clk, rst, stage_valid && !stage.last, !in_stall)
  `SXMA_ASSERT_IMP(a_found_not_short, clk, rst, out_valid,
                   !(out_data.found && out_data.too_short))
  `SXMA_ASSERT_IMP(a_zero_when_absent, clk, rst, out_valid && !out_data.found,
                   (out_data.mapped_ip == '0) && (out_data.mapped_port == '0))
  `SXMA_ASSERT_NXT(a_stage_holds, clk, rst, stage_valid && in_stall,
                   stage_valid && $stable(stage))

endmodule

// ===== test/stun_xor_mapped_address_parser_core_checker.sv =====
`timescale 1ns / 100ps
// checker for the stun xor-mapped-address parser: mirrors the attribute walk and compares results
module stun_xor_mapped_address_parser_core_checker #(
  parameter int unsigned MAX_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sxma_pkg::sxma_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sxma_pkg::sxma_out_t out_data,
  output int                  decodes_due,
  output int                  bad_fields
);
  import sxma_pkg::*;

  logic [16:0] byte_cnt;
  logic [16:0] attr_ofs;
  logic [15:0] attr_kind;
  logic [15:0] attr_len;
  logic [16:0] attr_span;
  logic        xma_done;
  logic        xma_cand;
  logic [31:0] held_ip;
  logic [15:0] held_port;

  sxma_out_t pending_decodes[$];

  function automatic void clear_walk();
    byte_cnt  = '0;
    attr_ofs  = '0;
    attr_kind = '0;
    attr_len  = '0;
    attr_span = '0;
    xma_done  = 1'b0;
    xma_cand  = 1'b0;
    held_ip   = '0;
    held_port = '0;
  endfunction

  task automatic walk_attr_byte(input logic [7:0] b);
    logic [16:0] body_pos;
    logic [16:0] rel;
    logic [1:0]  pad;
    if (xma_done || byte_cnt < HDR_BYTES) return;
    body_pos = byte_cnt - HDR_BYTES;
    if (body_pos < attr_ofs) return;
    rel = body_pos - attr_ofs;
    case (rel)
      REL_KIND_HI: attr_kind = {b, 8'h00};
      REL_KIND_LO: attr_kind = attr_kind | {8'h00, b};
      REL_LEN_HI:  attr_len = {b, 8'h00};
      REL_LEN_LO: begin
        attr_len  = attr_len | {8'h00, b};
        pad       = 2'd0 - attr_len[1:0];
        attr_span = 17'd4 + {1'b0, attr_len} + {15'd0, pad};
      end
      REL_FAMILY: begin
        xma_cand = (attr_kind == XMA_TYPE) && (attr_len >= MIN_XMA_LEN) && (b == FAMILY_V4);
      end
      REL_PORT_HI: held_port = {b, 8'h00};
      REL_PORT_LO: held_port = held_port | {8'h00, b};
      REL_IP_0, REL_IP_1, REL_IP_2, REL_IP_3: begin
        held_ip = {held_ip[23:0], b};
        if (rel == REL_IP_3 && xma_cand) begin
          // decoded values freeze here, the span bookkeeping is skipped
          xma_done  = 1'b1;
          held_ip   = held_ip ^ COOKIE;
          held_port = held_port ^ COOKIE[31:16];
          return;
        end
      end
      default: ;
    endcase
    if (rel >= REL_LEN_LO && rel + 17'd1 == attr_span) begin
      attr_ofs  = attr_ofs + attr_span;
      xma_cand  = 1'b0;
      held_ip   = '0;
      held_port = '0;
    end
  endtask

  function automatic sxma_out_t decode_outcome();
    sxma_out_t r;
    r.found       = xma_done;
    r.too_short   = (byte_cnt < HDR_BYTES);
    r.mapped_ip   = xma_done ? held_ip : 32'd0;
    r.mapped_port = xma_done ? held_port : 16'd0;
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      bad_fields++;
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sxma_out_t want;
    if (rst) begin
      clear_walk();
      pending_decodes.delete();
    end else begin
      // result side first so a transfer never meets an expectation pushed this edge
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          bad_fields++;
          $display("%0t: unexpected result, got %0h", $time, out_data);
        end else begin
          want = pending_decodes.pop_front();
          check_field("found", 32'(want.found), 32'(out_data.found));
          check_field("too_short", 32'(want.too_short), 32'(out_data.too_short));
          check_field("mapped_ip", want.mapped_ip, out_data.mapped_ip);
          check_field("mapped_port", 32'(want.mapped_port), 32'(out_data.mapped_port));
        end
      end
      if (in_valid && !in_stall) begin
        if (byte_cnt < MAX_BYTES) begin
          walk_attr_byte(in_data.data_byte);
          byte_cnt = byte_cnt + 17'd1;
        end
        if (in_data.last) begin
          pending_decodes.push_back(decode_outcome());
          clear_walk();
        end
      end
    end
    decodes_due <= pending_decodes.size();
  end

endmodule

// ===== test/stun_xor_mapped_address_parser_core_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the stun xor-mapped-address parser: message stimulus and verdict
module stun_xor_mapped_address_parser_core_tb;
  import sxma_pkg::*;

  localparam int unsigned MAX_BYTES    = 512;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_BYTES = 450;

  typedef logic [7:0] octet_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  sxma_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  sxma_out_t out_data;
  int        decodes_due;
  int        bad_fields;

  octet_t      msg_q[$];
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent;

  stun_xor_mapped_address_parser_core #(.MAX_BYTES(MAX_BYTES)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  stun_xor_mapped_address_parser_core_checker #(.MAX_BYTES(MAX_BYTES)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .decodes_due(decodes_due),
    .bad_fields (bad_fields)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    bit          hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void add_random(input int unsigned n);
    repeat (n) msg_q.push_back(octet_t'($urandom));
  endfunction

  function automatic void add_tlv_head(input logic [15:0] kind, input logic [15:0] len);
    msg_q.push_back(kind[15:8]);
    msg_q.push_back(kind[7:0]);
    msg_q.push_back(len[15:8]);
    msg_q.push_back(len[7:0]);
  endfunction

  function automatic void add_tlv(input logic [15:0] kind, input logic [15:0] len);
    int unsigned n;
    n = len;
    add_tlv_head(kind, len);
    add_random(n + (4 - n % 4) % 4);
  endfunction

  // port and address are given as they travel on the wire, before the cookie xor
  function automatic void add_xma(input logic [7:0] family, input logic [15:0] wire_port,
                                  input logic [31:0] wire_ip, input logic [15:0] len);
    int unsigned n;
    n = len;
    add_tlv_head(XMA_TYPE, len);
    msg_q.push_back(octet_t'($urandom));
    msg_q.push_back(family);
    msg_q.push_back(wire_port[15:8]);
    msg_q.push_back(wire_port[7:0]);
    msg_q.push_back(wire_ip[31:24]);
    msg_q.push_back(wire_ip[23:16]);
    msg_q.push_back(wire_ip[15:8]);
    msg_q.push_back(wire_ip[7:0]);
    add_random(n - 8 + (4 - n % 4) % 4);
  endfunction

  function automatic void trim_msg(input int unsigned n);
    while (msg_q.size() > n) msg_q.delete(msg_q.size() - 1);
  endfunction

  function automatic void build_random_msg();
    int unsigned sel;
    int unsigned n_attr;
    logic [7:0]  fam;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      add_random($urandom_range(1, 40));
      return;
    end
    if (sel == 1) begin
      add_random($urandom_range(1, 19));
      return;
    end
    add_random(HDR_BYTES);
    n_attr = $urandom_range(0, 3);
    repeat (n_attr) begin
      case ($urandom_range(0, 7))
        0, 1, 2: add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'($urandom_range(8, 14)));
        3: begin
          fam = octet_t'($urandom);
          if (fam == FAMILY_V4) fam = 8'h81;
          add_xma(fam, 16'($urandom), $urandom, 16'($urandom_range(8, 12)));
        end
        4: add_tlv(XMA_TYPE, 16'($urandom_range(0, 7)));
        5: add_tlv(16'($urandom), 16'($urandom_range(0, 12)));
        // type one bit away from a match
        6: add_tlv(XMA_TYPE ^ (16'd1 << $urandom_range(0, 15)), 16'($urandom_range(8, 12)));
        default: begin
          add_tlv_head(16'($urandom), 16'($urandom));
          add_random($urandom_range(0, 8));
        end
      endcase
    end
    if (sel == 2 || sel == 3) trim_msg($urandom_range(1, msg_q.size()));
    if (sel == 4 && $urandom_range(0, 2) == 0) add_random($urandom_range(440, 520));
  endfunction

  // one byte per transfer, last set on the final byte
  task automatic send_msg();
    sxma_in_t beat;
    for (int i = 0; i < msg_q.size(); i++) begin
      if (!tx_quiet && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 11)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      beat.data_byte = msg_q[i];
      beat.last      = (i == msg_q.size() - 1);
      @(negedge clk);
      in_valid <= 1'b1;
      in_data  <= beat;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    bytes_sent += msg_q.size();
    msg_q.delete();
  endtask

  task automatic wait_for_decodes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decodes_due != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned msg_cnt;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single byte and just under the header size
    msg_q.push_back(8'h00);
    send_msg();
    repeat (19) msg_q.push_back(8'hFF);
    send_msg();
    // header only
    add_random(HDR_BYTES);
    send_msg();
    // field extremes
    add_random(HDR_BYTES);
    add_xma(FAMILY_V4, 16'h0000, 32'h0000_0000, 16'd8);
    send_msg();
    add_random(HDR_BYTES);
    add_xma(FAMILY_V4, 16'hFFFF, 32'hFFFF_FFFF, 16'd8);
    send_msg();
    // wrong family skipped, next one decoded
    add_random(HDR_BYTES);
    add_xma(8'h02, 16'($urandom), $urandom, 16'd8);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd12);
    send_msg();
    // too short for a match, then padded and empty attributes
    add_random(HDR_BYTES);
    add_tlv(XMA_TYPE, 16'd7);
    add_tlv(16'h8022, 16'd5);
    add_tlv(16'h0001, 16'd0);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd10);
    send_msg();
    // match cut off one byte before its end
    add_random(HDR_BYTES);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd8);
    trim_msg(HDR_BYTES + 11);
    send_msg();
    // attribute header cut off
    add_random(HDR_BYTES);
    msg_q.push_back(8'h00);
    msg_q.push_back(8'h20);
    send_msg();
    // second match leaves the first decode alone
    add_random(HDR_BYTES);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd8);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd8);
    send_msg();
    // largest length runs past the message
    add_random(HDR_BYTES);
    add_tlv_head(16'hFFFF, 16'hFFFF);
    add_random(8);
    send_msg();
    // match straddles the buffer end
    add_random(HDR_BYTES);
    add_tlv(16'h0022, 16'd480);
    add_xma(FAMILY_V4, 16'($urandom), $urandom, 16'd8);
    send_msg();
    wait_for_decodes();

    bytes_sent = 0;
    msg_cnt = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (msg_cnt == 3) hold_req = 1'b1;
      build_random_msg();
      send_msg();
      msg_cnt++;
      if (msg_cnt % 4 == 0) wait_for_decodes();
    end

    // closing stretch with no idling on either side
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (4) begin
      build_random_msg();
      send_msg();
    end
    wait_for_decodes();
    repeat (10) @(negedge clk);

    if (bad_fields == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
